### rtl/pfds_pkg.sv
// ----------------------------------------------------------------------------
// pfds_pkg
// Shared constants, word types and address helper for the page framebuffer
// draw and refresh stream block.
// ----------------------------------------------------------------------------
package pfds_pkg;

    localparam int COLUMNS  = 128;
    localparam int PAGES    = 8;

    localparam int ROWS     = 8 * PAGES;
    localparam int PAGE_LEN = COLUMNS + 3;
    localparam int DEPTH    = COLUMNS * PAGES;

    localparam int COL_W    = 8;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAGE_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int OFF_W    = $clog2(PAGE_LEN);

    // operation codes
    localparam logic [2:0] FUNC_POINT  = 3'd0;
    localparam logic [2:0] FUNC_BYTE   = 3'd1;
    localparam logic [2:0] FUNC_INVERT = 3'd2;
    localparam logic [2:0] FUNC_CLEAR  = 3'd3;
    localparam logic [2:0] FUNC_STREAM = 3'd4;

    // refresh command bytes
    localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
    localparam logic [7:0] CMD_COL_LO    = 8'h00;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] x_column;
        logic [7:0] y_row;
        logic       pixel_on;
        logic [7:0] data_byte;
        logic [2:0] row_page;
        logic [7:0] span_length;
    } pfds_in_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] out_byte;
        logic       frame_last;
    } pfds_out_t;

    typedef struct packed {
        logic      push;
        pfds_out_t word;
    } pfds_push_t;

    // store index: column-major, PAGES bytes per column
    function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] col,
                                                   input logic [PAGE_W-1:0] page);
        return ADDR_W'(int'(col) * PAGES + int'(page));
    endfunction

endpackage

### rtl/page_framebuffer_draw_stream.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_stream
// Monochrome page frame store with draw operations and a refresh byte stream.
// ----------------------------------------------------------------------------
// Input words arrive on s_valid/s_ready/s_data; each selects set pixel, set
// byte, invert span, clear or stream next. Only stream next gives a result
// word, on m_valid/m_ready/m_data (command or display data byte, last flag).
// Per word: set pixel and an aligned set byte change one store byte, a set
// byte split over two pages changes two, invert span each column in turn,
// stream next reads one only for a data byte, and clear zeroes the whole
// store; a draw outside the store changes nothing. Each drawn byte is changed
// by a single read-then-write access to the one-port-pair frame RAM.
// A stream result sits in an output register. A command byte shows in the
// cycle after its word is accepted; a data byte passes the RAM read register
// first. While it waits, draw words are still taken; a further stream word
// waits until the register drains. After reset the store is swept to zero
// with s_ready low; the frame position starts at page 0, first command byte.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_stream
    import pfds_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pfds_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output pfds_out_t m_data
);

    logic              out_free;
    pfds_push_t        push;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic              m_valid_reg;
    pfds_out_t         m_data_reg;

    pfds_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_free  (out_free),
        .push      (push),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    pfds_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push.push) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= push.word;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/pfds_ram.sv
// ----------------------------------------------------------------------------
// pfds_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module pfds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pfds_ctrl.sv
// ----------------------------------------------------------------------------
// pfds_ctrl
// Operation sequencer: decodes input words, runs read-modify-write passes and
// clearing sweeps on the frame store, and walks the refresh frame position.
// ----------------------------------------------------------------------------
module pfds_ctrl
    import pfds_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfds_in_t          s_data,
    input  logic              out_free,
    output pfds_push_t        push,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [7:0]        ram_wdata,
    input  logic [7:0]        ram_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_STREAM
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   addr2_reg;
    logic [7:0]          operand_reg;
    logic [7:0]          operand2_reg;
    logic                invert_reg;
    logic                second_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    end_col_reg;
    logic [PAGE_W-1:0]   page_cnt_reg;
    logic [OFF_W-1:0]    off_reg;
    logic                last_reg;

    logic                accept;
    logic                x_ok;
    logic                y_ok;
    logic                line_ok;
    logic [PAGE_W-1:0]   y_page;
    logic [PAGE_W-1:0]   line_page;
    logic [7:0]          dat_eff;
    logic [15:0]         dat_split;
    logic [8:0]          span_sum;
    logic [COL_W-1:0]    span_end;
    logic [ADDR_W-1:0]   stream_addr;
    logic                stream_cmd;
    logic                stream_last;
    logic [7:0]          cmd_byte;

    // decode
    always_comb begin
        x_ok        = {1'b0, s_data.x_column} < 9'(COLUMNS);
        y_ok        = {1'b0, s_data.y_row} < 9'(ROWS);
        line_ok     = {2'b00, s_data.row_page} < 5'(PAGES);
        y_page      = PAGE_W'(PAGES - 1 - int'(s_data.y_row[7:3]));
        line_page   = PAGE_W'(PAGES - 1 - int'(s_data.row_page));
        dat_eff     = s_data.pixel_on ? s_data.data_byte : ~s_data.data_byte;
        // upper byte goes to this page, spill goes to the page below
        dat_split   = {dat_eff, 8'h00} >> s_data.y_row[2:0];
        span_sum    = {1'b0, s_data.x_column} + {1'b0, s_data.span_length};
        span_end    = (span_sum >= 9'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                : COL_W'(span_sum - 9'd1);
        stream_addr = addr_of(COL_W'(off_reg - OFF_W'(3)), page_cnt_reg);
        stream_cmd  = off_reg < OFF_W'(3);
        stream_last = (page_cnt_reg == PAGE_W'(PAGES - 1))
                   && (off_reg == OFF_W'(PAGE_LEN - 1));
        case (off_reg[1:0])
            2'd0:    cmd_byte = CMD_PAGE_BASE + 8'(page_cnt_reg);
            2'd1:    cmd_byte = CMD_COL_LO;
            default: cmd_byte = CMD_COL_HI;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == S_IDLE) && (out_free || s_data.func != FUNC_STREAM);
        accept    = s_valid && s_ready;
        ram_re    = 1'b0;
        ram_raddr = addr_reg;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = 8'h00;
        push      = '0;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
            end
            S_IDLE: begin
                ram_re = accept;
                case (s_data.func)
                    FUNC_STREAM: ram_raddr = stream_addr;
                    FUNC_INVERT: ram_raddr = addr_of(s_data.x_column, line_page);
                    default:     ram_raddr = addr_of(s_data.x_column, y_page);
                endcase
                if (accept && s_data.func == FUNC_STREAM && stream_cmd) begin
                    push.push            = 1'b1;
                    push.word.is_data    = 1'b0;
                    push.word.out_byte   = cmd_byte;
                    push.word.frame_last = stream_last;
                end
            end
            S_READ: begin
                ram_re = 1'b1;
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_wdata = invert_reg ? ~ram_rdata : (ram_rdata | operand_reg);
            end
            S_STREAM: begin
                push.push            = 1'b1;
                push.word.is_data    = 1'b1;
                push.word.out_byte   = ram_rdata;
                push.word.frame_last = last_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            page_cnt_reg <= '0;
            off_reg      <= '0;
            second_reg   <= 1'b0;
            invert_reg   <= 1'b0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        case (s_data.func)
                            FUNC_POINT: begin
                                if (x_ok && y_ok && s_data.pixel_on) begin
                                    addr_reg    <= addr_of(s_data.x_column, y_page);
                                    operand_reg <= 8'h80 >> s_data.y_row[2:0];
                                    invert_reg  <= 1'b0;
                                    second_reg  <= 1'b0;
                                    state_reg   <= S_WRITE;
                                end
                            end
                            FUNC_BYTE: begin
                                if (x_ok && y_ok) begin
                                    addr_reg     <= addr_of(s_data.x_column, y_page);
                                    operand_reg  <= dat_split[15:8];
                                    addr2_reg    <= addr_of(s_data.x_column,
                                                            y_page - 1'b1);
                                    operand2_reg <= dat_split[7:0];
                                    second_reg   <= (s_data.y_row[2:0] != 3'd0)
                                                 && (y_page != '0);
                                    invert_reg   <= 1'b0;
                                    state_reg    <= S_WRITE;
                                end
                            end
                            FUNC_INVERT: begin
                                if (line_ok && x_ok && s_data.span_length != 8'd0) begin
                                    addr_reg    <= addr_of(s_data.x_column, line_page);
                                    col_reg     <= s_data.x_column;
                                    end_col_reg <= span_end;
                                    invert_reg  <= 1'b1;
                                    second_reg  <= 1'b0;
                                    state_reg   <= S_WRITE;
                                end
                            end
                            FUNC_CLEAR: begin
                                clr_cnt_reg <= '0;
                                state_reg   <= S_CLEAR;
                            end
                            FUNC_STREAM: begin
                                last_reg <= stream_last;
                                if (off_reg == OFF_W'(PAGE_LEN - 1)) begin
                                    off_reg      <= '0;
                                    page_cnt_reg <= stream_last ? '0
                                                                : page_cnt_reg + 1'b1;
                                end else begin
                                    off_reg <= off_reg + 1'b1;
                                end
                                if (!stream_cmd) begin
                                    state_reg <= S_STREAM;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    if (second_reg) begin
                        addr_reg    <= addr2_reg;
                        operand_reg <= operand2_reg;
                        second_reg  <= 1'b0;
                        state_reg   <= S_READ;
                    end else if (invert_reg && col_reg != end_col_reg) begin
                        col_reg   <= col_reg + 1'b1;
                        addr_reg  <= addr_reg + ADDR_W'(PAGES);
                        state_reg <= S_READ;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_STREAM: begin
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_WRITE || state_reg == S_CLEAR))
        else $error("store written outside a write or clear phase");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push |-> out_free)
        else $error("result word pushed into a full output register");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.push && push.word.frame_last) |=> (off_reg == '0 && page_cnt_reg == '0))
        else $error("frame position did not wrap after the last word");

    a_stream_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STREAM) |-> $past(accept))
        else $error("data fetch phase without an accepted stream word");

endmodule
